/* rtl/core/ksh_pkg.sv */
// ----------------------------------------------------------------------------
// Keystroke sequence hash package
// Constants shared by the keystroke sequence hash block.
// ----------------------------------------------------------------------------
package ksh_pkg;

	localparam int unsigned KEY_W   = 16;
	localparam int unsigned TIME_W  = 32;
	localparam int unsigned HASH_W  = 32;
	localparam int unsigned CODE_W  = 8;
	localparam int unsigned PREV_W  = 9;

	localparam logic [KEY_W-1:0]  SINGLE_LIMIT = 16'h006B;
	localparam logic [KEY_W-1:0]  PACKED_LIMIT = 16'h6B00;
	localparam logic [CODE_W-1:0] NO_SINGLE    = 8'hFF;
	localparam logic [PREV_W-1:0] NO_PREV      = 9'h1FF;
	localparam logic [TIME_W-1:0] TIMEOUT_RST  = 32'd1000;

	localparam int unsigned KEY_SHL     = 11;
	localparam int unsigned MIX_SHR     = 17;
	localparam int unsigned MIX_SHL     = 4;
	localparam int unsigned SQ_SHR      = 29;
	localparam int unsigned SQ_SHL      = 3;
	localparam int unsigned FIN_SHR     = 11;
	localparam int unsigned FIN_SUM_SHL = 21;

endpackage

/* rtl/core/keystroke_sequence_hash.sv */
// ----------------------------------------------------------------------------
// Keystroke sequence hash
// Folds keyboard polls into three running hashes and emits the finished
// hash words once no new key has arrived for the idle timeout.
//
//   channel | direction | handshake           | payload
//   --------+-----------+---------------------+------------------------------
//   in      | input     | in_valid / in_ready   | key_word, now_time
//   out     | output    | out_valid / out_ready | final_code, final_code2, done_res
//   cfg     | input     | cfg_wr_en             | cfg_wr_data (idle_timeout)
//
// Every poll gives one result beat, which passes through the input register and
// then the result register. One poll is accepted per cycle while the output is
// not stalled; the hash update is combinational from the input register to the
// result register, and the next poll sees it. A stalled output holds the result
// register and the input register and then drops in_ready.
// Reset clears the hashes and stamp, sets the timeout to 1000 and empties
// both registers.
// ----------------------------------------------------------------------------
module keystroke_sequence_hash (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [ksh_pkg::KEY_W-1:0]         key_word,
	input  logic [ksh_pkg::TIME_W-1:0]        now_time,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [ksh_pkg::HASH_W-1:0]        final_code,
	output logic [ksh_pkg::HASH_W-1:0]        final_code2,
	output logic                              done_res,
	input  logic                              cfg_wr_en,
	input  logic [ksh_pkg::TIME_W-1:0]        cfg_wr_data
);

	logic                          valid_s1;
	logic [ksh_pkg::KEY_W-1:0]     key_word_s1;
	logic [ksh_pkg::TIME_W-1:0]    now_time_s1;

	logic                          out_valid_q;
	logic [ksh_pkg::HASH_W-1:0]    final_code_q;
	logic [ksh_pkg::HASH_W-1:0]    final_code2_q;
	logic                          done_res_q;

	logic [ksh_pkg::TIME_W-1:0]    idle_timeout_q;
	logic [ksh_pkg::HASH_W-1:0]    key_sum_q;
	logic [ksh_pkg::HASH_W-1:0]    shift_code_q;
	logic [ksh_pkg::HASH_W-1:0]    square_code_q;
	logic [ksh_pkg::PREV_W-1:0]    previous_key_q;
	logic [ksh_pkg::CODE_W-1:0]    single_key_q;
	logic [ksh_pkg::TIME_W-1:0]    stamp_time_q;

	logic                          advance;
	logic                          is_low;
	logic                          reject;
	logic                          fresh;
	logic                          expired;
	logic [ksh_pkg::CODE_W-1:0]    key;
	logic [2*ksh_pkg::CODE_W-1:0]  key_sq;
	logic [ksh_pkg::HASH_W-1:0]    mix;
	logic [ksh_pkg::TIME_W-1:0]    deadline;

	logic [ksh_pkg::HASH_W-1:0]    key_sum_d;
	logic [ksh_pkg::HASH_W-1:0]    shift_code_d;
	logic [ksh_pkg::HASH_W-1:0]    square_code_d;
	logic [ksh_pkg::PREV_W-1:0]    previous_key_d;
	logic [ksh_pkg::CODE_W-1:0]    single_key_d;
	logic [ksh_pkg::TIME_W-1:0]    stamp_time_d;
	logic [ksh_pkg::HASH_W-1:0]    final_code_d;
	logic [ksh_pkg::HASH_W-1:0]    final_code2_d;
	logic                          done_res_d;

	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	assign out_valid   = out_valid_q;
	assign final_code  = final_code_q;
	assign final_code2 = final_code2_q;
	assign done_res    = done_res_q;

	// Packed words carry the key in the low byte; single keys fit there too.
	assign key      = key_word_s1[ksh_pkg::CODE_W-1:0];
	assign key_sq   = {{ksh_pkg::CODE_W{1'b0}}, key} * {{ksh_pkg::CODE_W{1'b0}}, key};
	assign is_low   = key_word_s1 < ksh_pkg::SINGLE_LIMIT;
	assign reject   = !is_low && ((key_word_s1 > ksh_pkg::PACKED_LIMIT) ||
	                  (key_word_s1[ksh_pkg::KEY_W-1:ksh_pkg::CODE_W] != single_key_q));
	assign fresh    = (key != '0) && ({1'b0, key} != previous_key_q);
	assign deadline = stamp_time_q + idle_timeout_q;
	assign expired  = now_time_s1 > deadline;
	assign mix      = shift_code_q + {{(ksh_pkg::HASH_W-ksh_pkg::CODE_W-ksh_pkg::KEY_SHL){1'b0}},
	                  key, {ksh_pkg::KEY_SHL{1'b0}}};

	always_comb begin
		key_sum_d      = key_sum_q;
		shift_code_d   = shift_code_q;
		square_code_d  = square_code_q;
		previous_key_d = previous_key_q;
		single_key_d   = single_key_q;
		stamp_time_d   = stamp_time_q;
		final_code_d   = '0;
		final_code2_d  = '0;
		done_res_d     = 1'b0;
		if (is_low) begin
			single_key_d = key;
		end
		if (reject) begin
			key_sum_d    = '0;
			shift_code_d = '0;
		end else begin
			previous_key_d = {1'b0, key};
			if (fresh) begin
				key_sum_d     = key_sum_q + {{(ksh_pkg::HASH_W-ksh_pkg::CODE_W){1'b0}}, key};
				shift_code_d  = (mix >> ksh_pkg::MIX_SHR) + (mix << ksh_pkg::MIX_SHL);
				square_code_d = (square_code_q >> ksh_pkg::SQ_SHR) +
				                {{(ksh_pkg::HASH_W-2*ksh_pkg::CODE_W){1'b0}}, key_sq} +
				                (square_code_q << ksh_pkg::SQ_SHL);
				stamp_time_d  = now_time_s1;
			end else if (expired) begin
				final_code_d  = (shift_code_q >> ksh_pkg::FIN_SHR) +
				                (key_sum_q << ksh_pkg::FIN_SUM_SHL);
				final_code2_d = square_code_q;
				done_res_d    = 1'b1;
				key_sum_d     = '0;
				shift_code_d  = '0;
				square_code_d = '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1       <= 1'b0;
			out_valid_q    <= 1'b0;
			idle_timeout_q <= ksh_pkg::TIMEOUT_RST;
			key_sum_q      <= '0;
			shift_code_q   <= '0;
			square_code_q  <= '0;
			previous_key_q <= ksh_pkg::NO_PREV;
			single_key_q   <= ksh_pkg::NO_SINGLE;
			stamp_time_q   <= '0;
		end else begin
			if (cfg_wr_en) begin
				idle_timeout_q <= cfg_wr_data;
			end
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (advance) begin
				out_valid_q    <= 1'b1;
				key_sum_q      <= key_sum_d;
				shift_code_q   <= shift_code_d;
				square_code_q  <= square_code_d;
				previous_key_q <= previous_key_d;
				single_key_q   <= single_key_d;
				stamp_time_q   <= stamp_time_d;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			key_word_s1 <= key_word;
			now_time_s1 <= now_time;
		end
		if (advance) begin
			final_code_q  <= final_code_d;
			final_code2_q <= final_code2_d;
			done_res_q    <= done_res_d;
		end
	end

endmodule
